### rtl/core/lcu_pkg.sv
`default_nettype none
package lcu_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned RowW   = 10;
  localparam int unsigned ColW   = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AccW   = 64;
  localparam int unsigned SqW    = 63;
  localparam int unsigned LamW   = 31;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LAMBDA   = 2'd0,
    REG_ROW_LOW  = 2'd1,
    REG_ROW_HIGH = 2'd2,
    REG_SPARE    = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_ACC,
    ST_THR,
    ST_DIV,
    ST_FIN,
    ST_WR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [ColW-1:0]      out_column;
    logic signed [AccW-1:0] column_sum;
    logic [SqW-1:0]       square_sum;
    logic signed [DataW-1:0] new_coeff;
    logic signed [DataW-1:0] coeff_change;
    logic                 divide_fault;
    logic signed [DataW-1:0] residual_value;
  } result_t;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [RowW-1:0]         row;
    logic [ColW-1:0]         column_id;
    logic signed [DataW-1:0] entry_value;
    logic signed [DataW-1:0] coeff_or_delta;
    logic                    last;
  } item_t;

  // divider control
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

  function automatic logic signed [DataW-1:0] clamp32(input logic signed [AccW-1:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[DataW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                     input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    return s[AccW-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/lcu_if.sv
`default_nettype none
interface lcu_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/lcu_ram.sv
`default_nettype none
module lcu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/lcu_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle: |num| Q32.32 / den -> Q16.16
module lcu_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lcu_pkg::div_ctl_t      ctl,
  input  wire logic [63:0]            num_mag,
  input  wire logic [62:0]            den,
  output logic                        done,
  output logic signed [31:0]          quot
);
  import lcu_pkg::*;

  // 64 integer steps plus 16 fraction steps; saturation caught by bit 31+
  localparam int unsigned Steps = 80;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] num_r, num_nxt;
  logic [47:0] q_r, q_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic        ovf_r, ovf_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;
  logic        sat;

  always_comb begin
    rem_nxt = rem_r; num_nxt = num_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0; ovf_nxt = ovf_r;
    shifted = {rem_r[62:0], num_r[63]};
    trial = {1'b0, shifted} - {2'b00, den};
    if (ctl.start) begin
      rem_nxt = '0; num_nxt = num_mag; q_nxt = '0; cnt_nxt = '0;
      busy_nxt = 1'b1; neg_nxt = ctl.neg; ovf_nxt = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      // a set bit leaving the top of the quotient is kept as overflow
      ovf_nxt = ovf_r | q_r[47];
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; num_r <= num_nxt; q_r <= q_nxt; neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
  end

  // anything from bit 31 up saturates
  assign sat  = ovf_r | (|q_r[47:31]);
  assign done = done_r;
  always_comb begin
    if (sat) quot = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else if (neg_r) quot = -$signed({1'b0, q_r[30:0]});
    else quot = $signed({1'b0, q_r[30:0]});
  end
endmodule
`default_nettype wire

### rtl/core/lasso_coordinate_update_unit.sv
`default_nettype none
// Lasso coordinate update unit.
// Input channel (in_*): one word per column entry, residual load, residual
// update or residual read. Output channel (out_*): one word for a read or
// for the last entry of a column. Configuration (cfg_*): write-only, index
// 0 lambda, 1 first row, 2 last row of the update window; write when idle.
// A single 32x32 multiplier is reused under a sequencer: a column entry
// steps through accept, RAM read, four products and accumulate. The
// last entry of a column adds the soft threshold and an 80-step
// restoring divide (no divide when the square sum is zero). A load is
// accepted and written; an update takes two products and a RAM write; a
// read returns the residual. One word is in flight at a time; ready is
// low while it is worked on and while its result waits at the output.
// Reset clears lambda, the accumulators and the sequencer and sets the row
// window to 0..1023; the residual RAM is not cleared, holds junk until loaded.
// A stalled receiver holds the result register and the unit waits.
module lasso_coordinate_update_unit #(
  parameter int unsigned ROWS    = 1024,
  parameter int unsigned COLUMNS = 65536
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [30:0]           cfg_wdata,
  lcu_if.sink                        in_ch,
  lcu_if.source                      out_ch
);
  import lcu_pkg::*;

  localparam int unsigned AddrW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CidW  = $clog2(COLUMNS);

  // registers
  logic [LamW-1:0] lambda_r;
  logic [RowW-1:0] row_low_r, row_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= '0; row_low_r <= '0; row_high_r <= 10'd1023;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LAMBDA:   lambda_r   <= cfg_wdata;
        REG_ROW_LOW:  row_low_r  <= cfg_wdata[RowW-1:0];
        REG_ROW_HIGH: row_high_r <= cfg_wdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  item_t  it_r;
  item_t  in_w;
  logic signed [AccW-1:0] cacc_r, cacc_nxt;
  logic [SqW-1:0]         sacc_r, sacc_nxt;
  logic signed [AccW-1:0] vv_r, vr_r;          // v*v, v*res (or v*delta)
  logic [AccW-1:0]        pa_r, pb_r;          // |c|*vv_hi, |c|*vv_lo
  logic signed [AccW-1:0] thr_r;
  logic signed [DataW-1:0] res_q;
  logic                   row_ok;
  result_t                res_out_r;
  logic                   out_v_r;

  assign row_ok = ({{(32-RowW){1'b0}}, it_r.row} < 32'(ROWS));
  assign in_w   = in_ch.data;

  // residual RAM; the read is issued with the incoming word while idle
  logic ram_we;
  logic [DataW-1:0] ram_wd;
  logic [AddrW-1:0] ram_addr;
  assign ram_addr = (state_r == ST_IDLE) ? AddrW'(in_w.row) : AddrW'(it_r.row);
  lcu_ram #(.WIDTH(DataW), .DEPTH(ROWS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(ram_wd),
    .raddr(ram_addr), .rdata(res_q)
  );
  logic signed [DataW-1:0] res_v;
  assign res_v = row_ok ? res_q : '0;

  // shared multiplier, operands chosen by state
  logic signed [32:0] mop_a, mop_b;
  logic signed [65:0] mprod;
  logic [31:0] cmag;
  assign cmag = it_r.coeff_or_delta[31] ? 32'(-it_r.coeff_or_delta)
                                        : it_r.coeff_or_delta;
  always_comb begin
    mop_a = {it_r.entry_value[31], it_r.entry_value};
    mop_b = {it_r.entry_value[31], it_r.entry_value};
    case (state_r)
      ST_MUL_B: mop_b = it_r.kind == KIND_UPDATE
                      ? {it_r.coeff_or_delta[31], it_r.coeff_or_delta}
                      : {res_v[31], res_v};
      ST_MUL_C: begin mop_a = {1'b0, cmag}; mop_b = {1'b0, vv_r[63:32]}; end
      ST_MUL_D: begin mop_a = {1'b0, cmag}; mop_b = {1'b0, vv_r[31:0]}; end
      default: ;
    endcase
  end
  assign mprod = mop_a * mop_b;

  // divider
  div_ctl_t dctl;
  logic     ddone;
  logic signed [31:0] dquot;
  logic [63:0] thr_mag;
  assign thr_mag = thr_r[63] ? 64'(-thr_r) : 64'(thr_r);
  lcu_div u_div (.clk(clk), .rst_n(rst_n), .ctl(dctl), .num_mag(thr_mag),
                 .den(sacc_r), .done(ddone), .quot(dquot));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid && in_ch.ready) state_nxt = ST_RD;
      ST_RD:    state_nxt = (it_r.kind == KIND_LOAD) ? ST_IDLE :
                            (it_r.kind == KIND_READ) ? ST_OUT : ST_MUL_A;
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = (it_r.kind == KIND_UPDATE) ? ST_WR : ST_MUL_C;
      ST_MUL_C: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = it_r.last ? ST_THR : ST_IDLE;
      // no divide when the square sum is zero
      ST_THR:   state_nxt = (sacc_r == '0) ? ST_FIN : ST_DIV;
      ST_DIV:   if (ddone) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_OUT;
      ST_WR:    state_nxt = ST_IDLE;
      ST_OUT:   if (!out_v_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls
  logic [63:0] mcs;
  logic signed [AccW-1:0] cterm, vr_tz;
  logic [64:0] sq_s;
  logic signed [AccW-1:0] t_l;
  logic in_win;
  always_comb begin
    // |c|*vv >> 16 with saturation, sign restored
    if (pa_r > 64'h00007FFF_FFFFFFFF) mcs = 64'h8000_0000_0000_0000;
    else mcs = (pa_r << 16) + (pb_r >> 16);
    if (mcs[63] && !it_r.coeff_or_delta[31]) cterm = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (mcs[63]) cterm = {1'b1, 63'd0};
    else cterm = it_r.coeff_or_delta[31] ? -$signed(mcs) : $signed(mcs);
    sq_s = {2'b00, sacc_r} + {1'b0, vv_r};
    t_l = {18'd0, lambda_r, 15'd0};
    vr_tz = vr_r[63] ? -$signed(64'((-vr_r) >> 16)) : (vr_r >>> 16);
    in_win = (it_r.row >= row_low_r) && (it_r.row <= row_high_r);
    ram_we = 1'b0;
    ram_wd = it_r.entry_value;
    dctl = '{start: 1'b0, neg: thr_r[63]};
    cacc_nxt = cacc_r; sacc_nxt = sacc_r;
    case (state_r)
      ST_RD: ram_we = (it_r.kind == KIND_LOAD) && row_ok;
      ST_ACC: begin
        cacc_nxt = sat_add(sat_add(cacc_r, cterm), vr_r);
        sacc_nxt = sq_s[64:63] != 2'b00 ? {SqW{1'b1}} : sq_s[SqW-1:0];
      end
      ST_THR: dctl.start = sacc_r != '0;
      ST_FIN: begin
        cacc_nxt = '0;
        sacc_nxt = '0;
      end
      ST_WR: begin
        ram_we = row_ok && in_win && (it_r.coeff_or_delta != '0);
        ram_wd = clamp32(64'(res_v) + vr_tz);
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = res_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cacc_r <= '0; sacc_r <= '0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cacc_r <= cacc_nxt; sacc_r <= sacc_nxt;
      if ((state_r == ST_RD && it_r.kind == KIND_READ) || state_r == ST_FIN)
        out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready)
        out_v_r <= 1'b0;
    end
    if (state_r == ST_IDLE && in_ch.valid) it_r <= in_ch.data;
    if (state_r == ST_MUL_A) vv_r <= mprod[63:0];
    if (state_r == ST_MUL_B) vr_r <= mprod[63:0];
    if (state_r == ST_MUL_C) pa_r <= mprod[63:0];
    if (state_r == ST_MUL_D) pb_r <= mprod[63:0];
    if (state_r == ST_ACC) begin
      if (!cacc_nxt[63]) thr_r <= (cacc_nxt > t_l) ? cacc_nxt - t_l : '0;
      else thr_r <= (cacc_nxt < -t_l) ? cacc_nxt + t_l : '0;
    end
    // result word
    if (state_r == ST_RD && it_r.kind == KIND_READ) begin
      res_out_r <= '{out_column: it_r.column_id[CidW-1:0], column_sum: '0,
                     square_sum: '0, new_coeff: '0, coeff_change: '0,
                     divide_fault: 1'b0, residual_value: res_v};
    end else if (state_r == ST_FIN) begin
      res_out_r <= '{out_column: it_r.column_id[CidW-1:0], column_sum: cacc_r,
                     square_sum: sacc_r,
                     new_coeff: (sacc_r == '0) ? 32'sd0 : dquot,
                     coeff_change: clamp32(64'(it_r.coeff_or_delta)
                                   - 64'((sacc_r == '0) ? 32'sd0 : dquot)),
                     divide_fault: (sacc_r == '0), residual_value: '0};
    end
  end
endmodule
`default_nettype wire
